### hdl/zcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package zcd_pkg;

  localparam int CNT_W   = 8;
  localparam int LOST_W  = 7;
  localparam int VERD_W  = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // saturation limit of the qualifying row counter
  localparam logic [CNT_W-1:0] MAX_ROWS = 8'd128;
  localparam logic [CNT_W-1:0] CNT_SAT  = 8'd255;

  // verdict codes
  localparam logic [VERD_W-1:0] VERD_NONE  = 2'd0;
  localparam logic [VERD_W-1:0] VERD_AHEAD = 2'd1;
  localparam logic [VERD_W-1:0] VERD_LEFT  = 2'd2;
  localparam logic [VERD_W-1:0] VERD_RIGHT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MAX     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIPES_MIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIPES_MAX = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_MIN    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_MAX    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LOW    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_HIGH   = 4'd7;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_RUN_MIN     = 8'd4;
  localparam logic [CNT_W-1:0]  RST_RUN_MAX     = 8'd8;
  localparam logic [CNT_W-1:0]  RST_STRIPES_MIN = 8'd4;
  localparam logic [CNT_W-1:0]  RST_STRIPES_MAX = 8'd16;
  localparam logic [CNT_W-1:0]  RST_ROWS_MIN    = 8'd3;
  localparam logic [CNT_W-1:0]  RST_ROWS_MAX    = 8'd30;
  localparam logic [LOST_W-1:0] RST_LOST_LOW    = 7'd3;
  localparam logic [LOST_W-1:0] RST_LOST_HIGH   = 7'd20;

  typedef struct packed {
    logic [CNT_W-1:0]  run_min;
    logic [CNT_W-1:0]  run_max;
    logic [CNT_W-1:0]  stripes_min;
    logic [CNT_W-1:0]  stripes_max;
    logic [CNT_W-1:0]  rows_min;
    logic [CNT_W-1:0]  rows_max;
    logic [LOST_W-1:0] lost_low;
    logic [LOST_W-1:0] lost_high;
  } cfg_t;

  // row counter status handed to the frame decision
  typedef struct packed {
    logic             frame_end;
    logic [CNT_W-1:0] rows;
  } row_stat_t;

  function automatic logic in_range(input logic [CNT_W-1:0] v,
                                    input logic [CNT_W-1:0] lo,
                                    input logic [CNT_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage
`default_nettype wire

### hdl/zcd_stripe.sv
`timescale 1ns / 1ps
`default_nettype none
module zcd_stripe #(
  parameter logic [zcd_pkg::CNT_W-1:0] MAX_ROWS = zcd_pkg::MAX_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              pixel_black,
  input  wire logic              row_end,
  input  wire logic              frame_end,
  input  wire zcd_pkg::cfg_t     cfg,
  output zcd_pkg::row_stat_t     stat
);

  logic [zcd_pkg::CNT_W-1:0] run_length, run_length_next, run_mid;
  logic [zcd_pkg::CNT_W-1:0] stripe_count, stripe_count_next, stripe_mid;
  logic [zcd_pkg::CNT_W-1:0] row_count, row_count_next, row_mid;
  logic stripe_inc, row_inc, any_row_end;

  always_comb begin
    any_row_end = row_end | frame_end;
    // pixel first: a white pixel closes the current run
    stripe_inc = !pixel_black &&
                 zcd_pkg::in_range(run_length, cfg.run_min, cfg.run_max) &&
                 (stripe_count != zcd_pkg::CNT_SAT);
    stripe_mid = stripe_count + {{(zcd_pkg::CNT_W-1){1'b0}}, stripe_inc};
    if (pixel_black) begin
      run_mid = (run_length != zcd_pkg::CNT_SAT) ? run_length + 8'd1 : run_length;
    end else begin
      run_mid = '0;
    end
    // then the row evaluation
    row_inc = any_row_end &&
              zcd_pkg::in_range(stripe_mid, cfg.stripes_min, cfg.stripes_max) &&
              (row_count < MAX_ROWS);
    row_mid = row_count + {{(zcd_pkg::CNT_W-1){1'b0}}, row_inc};

    run_length_next   = any_row_end ? '0 : run_mid;
    stripe_count_next = any_row_end ? '0 : stripe_mid;
    row_count_next    = frame_end ? '0 : row_mid;

    stat.frame_end = frame_end;
    stat.rows      = row_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length   <= '0;
      stripe_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      run_length   <= run_length_next;
      stripe_count <= stripe_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule
`default_nettype wire

### hdl/zcd_verdict.sv
`timescale 1ns / 1ps
`default_nettype none
module zcd_verdict (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire zcd_pkg::row_stat_t             stat,
  input  wire logic [zcd_pkg::LOST_W-1:0]     left_lost_rows,
  input  wire logic [zcd_pkg::LOST_W-1:0]     right_lost_rows,
  input  wire zcd_pkg::cfg_t                  cfg,
  output logic [zcd_pkg::VERD_W-1:0]          verdict,
  output logic                                left_latched,
  output logic                                right_latched
);

  logic left_sticky, right_sticky;
  logic left_side, right_side, crossing;

  always_comb begin
    crossing   = zcd_pkg::in_range(stat.rows, cfg.rows_min, cfg.rows_max);
    left_side  = (left_lost_rows < cfg.lost_low) && (right_lost_rows > cfg.lost_high);
    right_side = (right_lost_rows < cfg.lost_low) && (left_lost_rows > cfg.lost_high);
    priority if (!crossing) begin
      verdict = zcd_pkg::VERD_NONE;
    end else if (left_side) begin
      verdict = zcd_pkg::VERD_LEFT;
    end else if (right_side) begin
      verdict = zcd_pkg::VERD_RIGHT;
    end else begin
      verdict = zcd_pkg::VERD_AHEAD;
    end
    // flags as they stand after this frame's update
    left_latched  = left_sticky  | (verdict == zcd_pkg::VERD_LEFT);
    right_latched = right_sticky | (verdict == zcd_pkg::VERD_RIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sticky  <= 1'b0;
      right_sticky <= 1'b0;
    end else if (step && stat.frame_end) begin
      left_sticky  <= left_latched;
      right_sticky <= right_latched;
    end
  end

endmodule
`default_nettype wire

### hdl/zebra_crossing_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// zebra crossing detector: one pixel beat per clock, no bubbles between beats, while no verdict beat is held up
// a pixel passes the input register, then the result register, on its way to the verdict beat
// throughput: 1 pixel per cycle while the result register is free to take a verdict
// a result beat goes out only for a pixel that carries frame end (tlast)
// rst (synchronous, active high) clears counters, sticky flags and valid bits
// and loads the default thresholds
module zebra_crossing_detector_top #(
  // saturation limit of the qualifying row counter
  parameter logic [zcd_pkg::CNT_W-1:0] MAX_ROWS = zcd_pkg::MAX_ROWS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // pixel stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [0] pixel_black, [1] row_end, [8:2] left_lost_rows, [15:9] right_lost_rows
  input  wire logic [zcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tlast,   // frame_end
  // verdict stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [1:0] verdict, [9:2] qualifying_rows, [10] left_latched, [11] right_latched,
  // [15:12] zero
  output logic [zcd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [zcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [zcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  zcd_pkg::cfg_t cfg;

  // input register
  logic                              in_valid;
  logic                              in_black;
  logic                              in_row_end;
  logic                              in_frame_end;
  logic [zcd_pkg::LOST_W-1:0]        in_left_lost;
  logic [zcd_pkg::LOST_W-1:0]        in_right_lost;

  // result register
  logic                              out_valid, out_valid_next;
  logic [zcd_pkg::OUT_TDATA_W-1:0]   out_data;

  logic                              out_free;
  logic                              step;
  zcd_pkg::row_stat_t                stat;
  logic [zcd_pkg::VERD_W-1:0]        verdict;
  logic                              left_latched;
  logic                              right_latched;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_min     <= zcd_pkg::RST_RUN_MIN;
      cfg.run_max     <= zcd_pkg::RST_RUN_MAX;
      cfg.stripes_min <= zcd_pkg::RST_STRIPES_MIN;
      cfg.stripes_max <= zcd_pkg::RST_STRIPES_MAX;
      cfg.rows_min    <= zcd_pkg::RST_ROWS_MIN;
      cfg.rows_max    <= zcd_pkg::RST_ROWS_MAX;
      cfg.lost_low    <= zcd_pkg::RST_LOST_LOW;
      cfg.lost_high   <= zcd_pkg::RST_LOST_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        zcd_pkg::REG_RUN_MIN:     cfg.run_min     <= cfg_data;
        zcd_pkg::REG_RUN_MAX:     cfg.run_max     <= cfg_data;
        zcd_pkg::REG_STRIPES_MIN: cfg.stripes_min <= cfg_data;
        zcd_pkg::REG_STRIPES_MAX: cfg.stripes_max <= cfg_data;
        zcd_pkg::REG_ROWS_MIN:    cfg.rows_min    <= cfg_data;
        zcd_pkg::REG_ROWS_MAX:    cfg.rows_max    <= cfg_data;
        zcd_pkg::REG_LOST_LOW:    cfg.lost_low    <= cfg_data[zcd_pkg::LOST_W-1:0];
        zcd_pkg::REG_LOST_HIGH:   cfg.lost_high   <= cfg_data[zcd_pkg::LOST_W-1:0];
        default: ;
      endcase
    end
  end

  // the registered pixel is processed whenever the result slot can take
  // whatever it produces; a pending verdict only blocks until it is taken
  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_black      <= s_axis_tdata[0];
      in_row_end    <= s_axis_tdata[1];
      in_left_lost  <= s_axis_tdata[8:2];
      in_right_lost <= s_axis_tdata[15:9];
      in_frame_end  <= s_axis_tlast;
    end
  end

  // run, stripe and row counters
  zcd_stripe #(
    .MAX_ROWS (MAX_ROWS)
  ) u_stripe (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .pixel_black (in_black),
    .row_end     (in_row_end),
    .frame_end   (in_frame_end),
    .cfg         (cfg),
    .stat        (stat)
  );

  // frame decision and sticky side flags
  zcd_verdict u_verdict (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .stat            (stat),
    .left_lost_rows  (in_left_lost),
    .right_lost_rows (in_right_lost),
    .cfg             (cfg),
    .verdict         (verdict),
    .left_latched    (left_latched),
    .right_latched   (right_latched)
  );

  always_comb begin
    if (step && in_frame_end) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_frame_end) begin
      out_data <= {4'b0000, right_latched, left_latched, stat.rows, verdict};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef SYNTHESIS
  // a verdict beat only appears after a frame-end pixel was processed
  a_beat_from_frame_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_valid && in_frame_end && out_free))
    else $error("verdict beat without frame end");

  // a side verdict always shows its sticky flag
  a_left_flag: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == zcd_pkg::VERD_LEFT) |-> m_axis_tdata[10])
    else $error("left verdict without left flag");

  a_right_flag: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == zcd_pkg::VERD_RIGHT) |-> m_axis_tdata[11])
    else $error("right verdict without right flag");

  // row counter never passes its saturation limit
  a_rows_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9:2] <= MAX_ROWS))
    else $error("qualifying rows above limit");
`endif

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int TOTAL_BEATS  = 1850;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [zcd_pkg::CNT_W-1:0]      cnt_t;
  typedef logic [zcd_pkg::LOST_W-1:0]     lost_t;
  typedef logic [zcd_pkg::CFG_IDX_W-1:0]  idx_t;
  typedef logic [zcd_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct {
    logic  black;
    logic  row_end;
    logic  frame_end;
    lost_t left_lost;
    lost_t right_lost;
  } pixel_t;

  typedef struct {
    logic [zcd_pkg::VERD_W-1:0] verdict;
    cnt_t                       qual_rows;
    logic                       left_flag;
    logic                       right_flag;
  } verdict_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [zcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [zcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we = 1'b0;
  idx_t                            cfg_index = '0;
  cfg_word_t                       cfg_data = '0;

  // mirror of the detector: thresholds, counters and sticky side flags
  zcd_pkg::cfg_t thr;
  cnt_t          run_len = '0;
  cnt_t          stripe_cnt = '0;
  cnt_t          row_cnt = '0;
  logic          left_seen = 1'b0;
  logic          right_seen = 1'b0;

  verdict_beat_t pending_verdicts[$];
  verdict_beat_t want;
  int            mismatch_count = 0;
  int            beats_sent = 0;
  int            cycle_count = 0;

  // idle pattern state for both sides
  bit tx_gaps = 1'b1;
  int tx_quiet = 0;
  int rx_quiet = 0;
  int rx_stall = 0;
  int long_hold = 0;

  zebra_crossing_detector_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(15, 40);
  endfunction

  // receiver: a requested long hold wins, otherwise random stalls and quiet stretches
  always @(posedge clk) begin
    if (long_hold > 0) begin
      m_axis_tready <= 1'b0;
      long_hold = long_hold - 1;
    end else if (rx_quiet > 0) begin
      m_axis_tready <= 1'b1;
      rx_quiet = rx_quiet - 1;
    end else if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 3) rx_quiet = $urandom_range(20, 120);
      else if ($urandom_range(0, 3) == 0) rx_stall = gap_length();
    end
  end

  // expected verdict beats, one per frame end
  function automatic void predict_verdict(input pixel_t p);
    verdict_beat_t r;
    logic          row_done;
    row_done = p.row_end | p.frame_end;
    // pixel is classified before the row end is looked at
    if (p.black) begin
      if (run_len != zcd_pkg::CNT_SAT) run_len++;
    end else begin
      if (run_len >= thr.run_min && run_len <= thr.run_max &&
          stripe_cnt != zcd_pkg::CNT_SAT)
        stripe_cnt++;
      run_len = '0;
    end
    // a run still open at row end is dropped
    if (row_done) begin
      if (stripe_cnt >= thr.stripes_min && stripe_cnt <= thr.stripes_max &&
          row_cnt < zcd_pkg::MAX_ROWS)
        row_cnt++;
      stripe_cnt = '0;
      run_len    = '0;
    end
    if (p.frame_end) begin
      r.verdict = zcd_pkg::VERD_NONE;
      if (row_cnt >= thr.rows_min && row_cnt <= thr.rows_max) begin
        // left side wins when both patterns would match
        if (p.left_lost < thr.lost_low && p.right_lost > thr.lost_high) begin
          r.verdict = zcd_pkg::VERD_LEFT;
          left_seen = 1'b1;
        end else if (p.right_lost < thr.lost_low && p.left_lost > thr.lost_high) begin
          r.verdict = zcd_pkg::VERD_RIGHT;
          right_seen = 1'b1;
        end else begin
          r.verdict = zcd_pkg::VERD_AHEAD;
        end
      end
      r.qual_rows  = row_cnt;
      r.left_flag  = left_seen;
      r.right_flag = right_seen;
      pending_verdicts.push_back(r);
      row_cnt = '0;
    end
  endfunction

  // verdict beat checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict beat with nothing pending: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[1:0] !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, m_axis_tdata[1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[9:2] !== want.qual_rows) begin
          $error("qualifying_rows: expected %0d, actual %0d", want.qual_rows,
                 m_axis_tdata[9:2]);
          mismatch_count++;
        end
        if (m_axis_tdata[10] !== want.left_flag) begin
          $error("left_latched: expected %0d, actual %0d", want.left_flag, m_axis_tdata[10]);
          mismatch_count++;
        end
        if (m_axis_tdata[11] !== want.right_flag) begin
          $error("right_latched: expected %0d, actual %0d", want.right_flag,
                 m_axis_tdata[11]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:12] !== 4'd0) begin
          $error("padding: expected 0, actual %0d", m_axis_tdata[15:12]);
          mismatch_count++;
        end
      end
    end
  end

  // one pixel beat, with an optional idle gap in front of it
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = 0;
    if (tx_gaps) begin
      if (tx_quiet > 0) tx_quiet--;
      else if ($urandom_range(0, 49) == 0) tx_quiet = $urandom_range(20, 100);
      else if ($urandom_range(0, 3) == 0) gap = gap_length();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.right_lost, p.left_lost, p.row_end, p.black};
    s_axis_tlast  <= p.frame_end;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    predict_verdict(p);
    beats_sent++;
  endtask

  // wait until every verdict is in, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input idx_t idx, input cfg_word_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      zcd_pkg::REG_RUN_MIN:     thr.run_min     = data;
      zcd_pkg::REG_RUN_MAX:     thr.run_max     = data;
      zcd_pkg::REG_STRIPES_MIN: thr.stripes_min = data;
      zcd_pkg::REG_STRIPES_MAX: thr.stripes_max = data;
      zcd_pkg::REG_ROWS_MIN:    thr.rows_min    = data;
      zcd_pkg::REG_ROWS_MAX:    thr.rows_max    = data;
      zcd_pkg::REG_LOST_LOW:    thr.lost_low    = data[zcd_pkg::LOST_W-1:0];
      zcd_pkg::REG_LOST_HIGH:   thr.lost_high   = data[zcd_pkg::LOST_W-1:0];
      default: ;
    endcase
  endtask

  // a write to an unused index first, then every register; the top bit of the
  // lost thresholds is random and must be dropped
  task automatic set_config(input zcd_pkg::cfg_t c);
    write_reg(idx_t'($urandom_range(8, 15)), cfg_word_t'($urandom_range(0, 255)));
    write_reg(zcd_pkg::REG_RUN_MIN, c.run_min);
    write_reg(zcd_pkg::REG_RUN_MAX, c.run_max);
    write_reg(zcd_pkg::REG_STRIPES_MIN, c.stripes_min);
    write_reg(zcd_pkg::REG_STRIPES_MAX, c.stripes_max);
    write_reg(zcd_pkg::REG_ROWS_MIN, c.rows_min);
    write_reg(zcd_pkg::REG_ROWS_MAX, c.rows_max);
    write_reg(zcd_pkg::REG_LOST_LOW, {1'($urandom_range(0, 1)), c.lost_low});
    write_reg(zcd_pkg::REG_LOST_HIGH, {1'($urandom_range(0, 1)), c.lost_high});
    cfg_we <= 1'b0;
  endtask

  function automatic zcd_pkg::cfg_t thresholds(input int rmin, input int rmax,
                                               input int smin, input int smax,
                                               input int qmin, input int qmax,
                                               input int llow, input int lhigh);
    zcd_pkg::cfg_t c;
    c.run_min     = cnt_t'(rmin);
    c.run_max     = cnt_t'(rmax);
    c.stripes_min = cnt_t'(smin);
    c.stripes_max = cnt_t'(smax);
    c.rows_min    = cnt_t'(qmin);
    c.rows_max    = cnt_t'(qmax);
    c.lost_low    = lost_t'(llow);
    c.lost_high   = lost_t'(lhigh);
    return c;
  endfunction

  // small windows keep frames short; some settings hit the corners
  function automatic zcd_pkg::cfg_t random_thresholds();
    zcd_pkg::cfg_t c;
    c.run_min     = cnt_t'($urandom_range(1, 3));
    c.run_max     = cnt_t'(c.run_min + $urandom_range(0, 3));
    c.stripes_min = cnt_t'($urandom_range(0, 3));
    c.stripes_max = cnt_t'(c.stripes_min + $urandom_range(0, 3));
    c.rows_min    = cnt_t'($urandom_range(0, 3));
    c.rows_max    = cnt_t'(c.rows_min + $urandom_range(0, 3));
    c.lost_low    = lost_t'($urandom_range(0, 12));
    c.lost_high   = lost_t'(c.lost_low + $urandom_range(0, 40));
    case ($urandom_range(0, 9))
      0: c = thresholds(int'(zcd_pkg::RST_RUN_MIN), int'(zcd_pkg::RST_RUN_MAX),
                        int'(zcd_pkg::RST_STRIPES_MIN), int'(zcd_pkg::RST_STRIPES_MAX),
                        int'(zcd_pkg::RST_ROWS_MIN), int'(zcd_pkg::RST_ROWS_MAX),
                        int'(zcd_pkg::RST_LOST_LOW), int'(zcd_pkg::RST_LOST_HIGH));
      1: c.run_min = '0;                       // back-to-back whites count as stripes
      2: c.run_min = cnt_t'(c.run_max + 1);    // inverted run window
      3: c.stripes_min = cnt_t'(c.stripes_max + 1);  // inverted stripe window
      4: c.rows_min = cnt_t'(c.rows_max + 1);  // inverted row window
      5: begin
        c.lost_low  = '0;                      // never a side crossing
        c.lost_high = lost_t'(127);
      end
      6: begin
        c.lost_low  = lost_t'(127);            // side decided by strict compares only
        c.lost_high = '0;
      end
      7: begin
        c.run_max     = cnt_t'(255);
        c.stripes_max = cnt_t'(255);
        c.rows_max    = cnt_t'(255);
      end
      default: ;
    endcase
    return c;
  endfunction

  // lost-edge counts near the thresholds and at the ends of the range
  function automatic lost_t pick_lost();
    int v;
    case ($urandom_range(0, 6))
      0: v = 0;
      1: v = int'(thr.lost_low) - 1;
      2: v = int'(thr.lost_low);
      3: v = int'(thr.lost_high);
      4: v = int'(thr.lost_high) + 1;
      5: v = 127;
      default: v = $urandom_range(0, 127);
    endcase
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    return v[zcd_pkg::LOST_W-1:0];
  endfunction

  function automatic pixel_t px(input logic black, input logic row_end);
    pixel_t p;
    p.black      = black;
    p.row_end    = row_end;
    p.frame_end  = 1'b0;
    p.left_lost  = lost_t'($urandom_range(0, 127));
    p.right_lost = lost_t'($urandom_range(0, 127));
    return p;
  endfunction

  function automatic pixel_t end_pixel(input logic black, input logic row_end,
                                       input int left, input int right);
    pixel_t p;
    p.black      = black;
    p.row_end    = row_end;
    p.frame_end  = 1'b1;
    p.left_lost  = lost_t'(left);
    p.right_lost = lost_t'(right);
    return p;
  endfunction

  // one row window: white gaps and black runs around the run window, sometimes
  // plain noise with stray row ends
  task automatic send_row(input bit last);
    pixel_t row_q[$];
    pixel_t p;
    int     nruns, lo, hi, cap;
    cap = thr.stripes_max + 1;
    if (cap > 5) cap = 5;
    lo = (thr.run_min > 1) ? thr.run_min - 1 : 1;
    hi = thr.run_max + 1;
    if (hi > 10) hi = 10;
    if (lo > hi) lo = hi;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) row_q.push_back(px(1'($urandom_range(0, 1)),
                                                         1'($urandom_range(0, 1))));
    end else begin
      nruns = $urandom_range(0, cap);
      repeat (nruns) begin
        repeat ($urandom_range(1, 2)) row_q.push_back(px(1'b0, 1'b0));
        repeat ($urandom_range(lo, hi)) row_q.push_back(px(1'b1, 1'b0));
      end
      // closes the last run or leaves it open at row end
      row_q.push_back(px(1'($urandom_range(0, 1)), 1'b0));
    end
    p = row_q.pop_back();
    p.row_end   = !(last && $urandom_range(0, 3) == 0);
    p.frame_end = last;
    if (last) begin
      p.left_lost  = pick_lost();
      p.right_lost = pick_lost();
    end
    row_q.push_back(p);
    foreach (row_q[i]) send_pixel(row_q[i]);
  endtask

  task automatic send_frame();
    int cap;
    cap = thr.rows_max + 2;
    if (cap > 6) cap = 6;
    repeat ($urandom_range(0, cap)) send_row(1'b0);
    send_row(1'b1);
  endtask

  // hand-built frames: every verdict, row and frame end corner cases
  task automatic test_directed_frames();
    set_config(thresholds(1, 2, 1, 2, 1, 2, 3, 20));
    // white last pixel closes the run before the row is judged; frame end alone
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b0, 1'b1));
    send_pixel(end_pixel(1'b0, 1'b0, 50, 50));
    // run open at row end is dropped; left present, right lost
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b1, 1'b1));
    send_pixel(px(1'b0, 1'b0));
    send_pixel(px(1'b1, 1'b0));
    send_pixel(end_pixel(1'b0, 1'b1, 0, 127));
    // too long a run; right present, left lost
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b0, 1'b0));
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b0, 1'b1));
    send_pixel(end_pixel(1'b0, 1'b1, 127, 0));
    // no qualifying rows, flags stay set
    send_pixel(end_pixel(1'b1, 1'b1, 0, 127));
    // lost counts equal to the thresholds are neither present nor lost
    send_pixel(px(1'b1, 1'b0));
    send_pixel(end_pixel(1'b0, 1'b1, 3, 20));
    // one qualifying row too many
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b0, 1'b1));
    send_pixel(px(1'b1, 1'b0));
    send_pixel(px(1'b0, 1'b1));
    send_pixel(px(1'b1, 1'b0));
    send_pixel(end_pixel(1'b0, 1'b1, 2, 21));
    drain();
  endtask

  // run length, stripe count and row count at their limits
  task automatic test_counter_saturation();
    set_config(thresholds(255, 255, 1, 1, 1, 1, 3, 20));
    repeat (300) send_pixel(px(1'b1, 1'b0));
    send_pixel(end_pixel(1'b0, 1'b1, 50, 50));
    repeat (254) send_pixel(px(1'b1, 1'b0));
    send_pixel(end_pixel(1'b0, 1'b1, 50, 50));
    drain();

    set_config(thresholds(1, 1, 255, 255, 1, 1, 3, 20));
    for (int i = 0; i < 260; i++) begin
      send_pixel(px(1'b1, 1'b0));
      if (i < 259) send_pixel(px(1'b0, 1'b0));
      else send_pixel(end_pixel(1'b0, 1'b1, 50, 50));
    end
    drain();

    // every single-pixel row qualifies, row counter stops at MAX_ROWS
    set_config(thresholds(1, 8, 0, 255, 128, 255, 3, 20));
    repeat (139) send_pixel(px(1'b0, 1'b1));
    send_pixel(end_pixel(1'b0, 1'b1, 50, 50));
    drain();
  endtask

  // output held off for a long stretch while short frames keep coming
  task automatic test_output_backpressure();
    set_config(thresholds(1, 2, 1, 2, 0, 3, 3, 20));
    tx_gaps   = 1'b0;
    long_hold = 300;
    repeat (40) begin
      send_pixel(px(1'b1, 1'b0));
      send_pixel(end_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           int'(pick_lost()), int'(pick_lost())));
    end
    tx_gaps = 1'b1;
    drain();
  endtask

  // random frames fill the run up to the overall beat count
  task automatic test_random_frames();
    while (beats_sent < TOTAL_BEATS) begin
      set_config(random_thresholds());
      repeat ($urandom_range(3, 8)) send_frame();
      drain();
    end
  endtask

  initial begin
    thr = thresholds(int'(zcd_pkg::RST_RUN_MIN), int'(zcd_pkg::RST_RUN_MAX),
                     int'(zcd_pkg::RST_STRIPES_MIN), int'(zcd_pkg::RST_STRIPES_MAX),
                     int'(zcd_pkg::RST_ROWS_MIN), int'(zcd_pkg::RST_ROWS_MAX),
                     int'(zcd_pkg::RST_LOST_LOW), int'(zcd_pkg::RST_LOST_HIGH));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_counter_saturation();
    test_output_backpressure();
    test_random_frames();
    drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
